@@ src/multiplexed_seven_segment_counter_defines.svh @@
// assertion macros used by the counter core (msc_core)
// expects clk and arst_n in the scope of each use
`ifndef MULTIPLEXED_SEVEN_SEGMENT_COUNTER_DEFINES_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_COUNTER_DEFINES_SVH

// condition implies consequence in the same cycle
`define MSC_ASSERT_SAME(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define MSC_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

@@ src/msc_pkg.sv @@
// types, constants and the digit table of the seven-segment counter
// no dependencies
package msc_pkg;

	localparam int MODE_COUNT = 4;
	localparam int DWELL_W    = 10;
	localparam int MODE_W     = 3;
	localparam int COUNT_W    = 14;
	localparam int REG_IDX_W  = 2;

	localparam logic [MODE_W-1:0] MODE_IDLE = 3'd0;
	localparam logic [7:0]        SEG_BLANK = 8'hFF;

	// register indexes on the configuration port
	localparam logic [REG_IDX_W-1:0] REG_DWELL_ONE   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DWELL_TWO   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DWELL_THREE = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_DWELL_FOUR  = 2'd3;

	localparam logic [DWELL_W-1:0] DWELL_ONE_RST   = 10'd1000;
	localparam logic [DWELL_W-1:0] DWELL_TWO_RST   = 10'd500;
	localparam logic [DWELL_W-1:0] DWELL_THREE_RST = 10'd333;
	localparam logic [DWELL_W-1:0] DWELL_FOUR_RST  = 10'd250;

	// frames per count step, indexed by mode minus one
	typedef logic [MODE_COUNT-1:0][DWELL_W-1:0] dwell_t;

	function automatic logic [7:0] seg_lookup(input logic [3:0] digit);
		logic [7:0] seg;
		case (digit)
			4'd0: seg = 8'hC0;
			4'd1: seg = 8'hF9;
			4'd2: seg = 8'hA4;
			4'd3: seg = 8'hA8;
			4'd4: seg = 8'h99;
			4'd5: seg = 8'h8A;
			4'd6: seg = 8'h82;
			4'd7: seg = 8'hF8;
			4'd8: seg = 8'h80;
			4'd9: seg = 8'h88;
			default: seg = 8'hC0;
		endcase
		return seg;
	endfunction

endpackage

@@ src/msc_regs.sv @@
// apb register file holding the four dwell registers
// depends on msc_pkg
module msc_regs
	import msc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output dwell_t      dwell
);

	dwell_t                 dwell_q;
	logic                   wr_en;
	logic [REG_IDX_W-1:0]   reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];
	assign dwell   = dwell_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_q[0] <= DWELL_ONE_RST;
			dwell_q[1] <= DWELL_TWO_RST;
			dwell_q[2] <= DWELL_THREE_RST;
			dwell_q[3] <= DWELL_FOUR_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DWELL_ONE:   dwell_q[0] <= pwdata[DWELL_W-1:0];
				REG_DWELL_TWO:   dwell_q[1] <= pwdata[DWELL_W-1:0];
				REG_DWELL_THREE: dwell_q[2] <= pwdata[DWELL_W-1:0];
				REG_DWELL_FOUR:  dwell_q[3] <= pwdata[DWELL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DWELL_ONE:   prdata = {22'd0, dwell_q[0]};
			REG_DWELL_TWO:   prdata = {22'd0, dwell_q[1]};
			REG_DWELL_THREE: prdata = {22'd0, dwell_q[2]};
			REG_DWELL_FOUR:  prdata = {22'd0, dwell_q[3]};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

@@ src/msc_core.sv @@
// counter state, per-tick scan logic and result register
// depends on msc_pkg and the defines header
`include "multiplexed_seven_segment_counter_defines.svh"
module msc_core
	import msc_pkg::*;
#(
	parameter int MAX_DIGITS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dwell_t             dwell,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         switch_n,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         digit_enable,
	output logic [7:0]         segment_pattern,
	output logic [MODE_W-1:0]  active_mode,
	output logic [COUNT_W-1:0] count_value
);

	localparam int NUM_DIG = (MAX_DIGITS < MODE_COUNT) ? MAX_DIGITS : MODE_COUNT;
	localparam int IDX_W   = (NUM_DIG > 1) ? $clog2(NUM_DIG) : 1;

	logic [MODE_W-1:0]              mode_q, mode_w;
	logic [NUM_DIG-1:0][3:0]        bcd_q, bcd_w, bcd_n;
	logic [1:0]                     scan_q, scan_n, pos;
	logic [DWELL_W-1:0]             frame_q, frame_w, frame_n;
	logic                           accept;
	logic                           out_valid_q;
	logic [3:0]                     en_c, en_q;
	logic [7:0]                     seg_c, seg_q;
	logic [COUNT_W-1:0]             cnt_c, cnt_q;
	logic [MODE_W-1:0]              amode_q;

	assign in_ready        = !out_valid_q || out_ready;
	assign accept          = in_valid && in_ready;
	assign out_valid       = out_valid_q;
	assign digit_enable    = en_q;
	assign segment_pattern = seg_q;
	assign active_mode     = amode_q;
	assign count_value     = cnt_q;

	always_comb begin
		logic            found;
		logic            carry;
		logic [IDX_W-1:0] idx;
		logic [3:0]      digit;
		logic [4:0]      bitpos;
		logic [DWELL_W:0] sum;
		logic [DWELL_W-1:0] limit;

		mode_w  = mode_q;
		bcd_w   = bcd_q;
		frame_w = frame_q;
		found   = 1'b0;
		// mode select only at a frame start, first pressed switch other than the current mode wins
		if (scan_q == 2'd0) begin
			for (int s = 1; s <= MODE_COUNT; s++) begin
				if (!found && MODE_W'(s) != mode_q && s <= MAX_DIGITS && !switch_n[s-1]) begin
					mode_w  = MODE_W'(s);
					bcd_w   = '0;
					frame_w = '0;
					found   = 1'b1;
				end
			end
		end

		bcd_n   = bcd_w;
		frame_n = frame_w;
		scan_n  = 2'd0;
		pos     = 2'd0;
		idx     = '0;
		digit   = 4'd0;
		bitpos  = 5'd0;
		sum     = '0;
		limit   = '0;
		carry   = 1'b0;
		en_c    = 4'd0;
		seg_c   = SEG_BLANK;
		cnt_c   = '0;

		if (mode_w != MODE_IDLE) begin
			pos    = ({1'b0, scan_q} >= mode_w) ? 2'd0 : scan_q;
			idx    = IDX_W'(mode_w - 3'd1 - {1'b0, pos});
			digit  = bcd_w[idx];
			bitpos = 5'(MAX_DIGITS) - {2'b00, mode_w} + {3'b000, pos};
			en_c   = (bitpos < 5'd4) ? (4'b0001 << bitpos[1:0]) : 4'd0;
			seg_c  = seg_lookup((digit < 4'd10) ? digit : 4'd0);
			for (int i = NUM_DIG - 1; i >= 0; i--) begin
				if (MODE_W'(i) < mode_w)
					cnt_c = COUNT_W'(cnt_c * COUNT_W'(10) + COUNT_W'(bcd_w[i]));
			end

			if ({1'b0, pos} + 3'd1 >= mode_w) begin
				// end of frame
				scan_n = 2'd0;
				sum    = {1'b0, frame_w} + 1'b1;
				limit  = dwell[REG_IDX_W'(mode_w - 3'd1)];
				if (sum >= {1'b0, limit}) begin
					frame_n = '0;
					carry   = 1'b1;
					for (int i = 0; i < NUM_DIG; i++) begin
						if (carry && MODE_W'(i) < mode_w) begin
							if (bcd_w[i] >= 4'd9) begin
								bcd_n[i] = 4'd0;
							end else begin
								bcd_n[i] = bcd_w[i] + 4'd1;
								carry    = 1'b0;
							end
						end
					end
				end else begin
					frame_n = sum[DWELL_W-1:0];
				end
			end else begin
				scan_n = pos + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			bcd_q       <= '0;
			scan_q      <= 2'd0;
			frame_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q      <= mode_w;
				bcd_q       <= bcd_n;
				scan_q      <= scan_n;
				frame_q     <= frame_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded on every input transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			en_q    <= en_c;
			seg_q   <= seg_c;
			cnt_q   <= cnt_c;
			amode_q <= mode_w;
		end
	end

	`MSC_ASSERT_SAME(a_idle_blank, out_valid_q && amode_q == MODE_IDLE,
		en_q == 4'd0 && seg_q == SEG_BLANK && cnt_q == '0, "idle result not blank")
	`MSC_ASSERT_SAME(a_enable_onehot, out_valid_q, $onehot0(en_q),
		"digit enable not one-hot")
	`MSC_ASSERT_SAME(a_scan_in_frame, mode_q != MODE_IDLE, {1'b0, scan_q} < mode_q,
		"scan position beyond digit count")
	`MSC_ASSERT_NEXT(a_mode_mid_frame, accept && scan_q != 2'd0, mode_q == $past(mode_q),
		"mode changed in mid-frame")

endmodule

@@ src/multiplexed_seven_segment_counter.sv @@
// Multiplexed seven-segment BCD counter, top level.
// Slave stream: one transfer per millisecond tick, s_tdata carries the four
// active-low switch levels. Master stream: one result per tick with the digit
// enable, segment byte, active mode and decimal count of the display.
// APB port: four 10-bit dwell registers (frames per count step) at 0x0,
// 0x4, 0x8 and 0xC for one to four digit modes; pready is always high.
// The result of a tick is registered and is on the master side in the cycle after
// its transfer. Throughput: one tick per cycle while the receiver takes each
// result, set by the single result register after the per-tick scan and count logic.
// When the receiver stalls the result holds and s_tready drops until the
// result register is taken or drained in the same cycle.
// Reset: idle mode, no valid result, count and frame counter cleared, dwell
// registers at 1000, 500, 333 and 250. Pressing switch N (N up to MAX_DIGITS) at
// a frame start selects N digits and clears the count, unless N is the current mode.
// Depends on msc_pkg, msc_regs and msc_core.
module multiplexed_seven_segment_counter
	import msc_pkg::*;
#(
	parameter int MAX_DIGITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// tick stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: switch_one_n, switch_two_n, switch_three_n, switch_four_n, zero pad
	input  logic [7:0]  s_tdata,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: digit_enable[3:0], segment_pattern[11:4], active_mode[14:12],
	// count_value[28:15], zero pad
	output logic [31:0] m_tdata
);

	dwell_t             dwell;
	logic [3:0]         digit_enable;
	logic [7:0]         segment_pattern;
	logic [MODE_W-1:0]  active_mode;
	logic [COUNT_W-1:0] count_value;

	msc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.dwell   (dwell)
	);

	msc_core #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.dwell           (dwell),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.switch_n        (s_tdata[3:0]),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.digit_enable    (digit_enable),
		.segment_pattern (segment_pattern),
		.active_mode     (active_mode),
		.count_value     (count_value)
	);

	assign m_tdata = {3'd0, count_value, active_mode, segment_pattern, digit_enable};

endmodule

@@ tb/testbench.sv @@
// self-checking bench for multiplexed_seven_segment_counter: switch ticks in, display results out
// predicts scan, mode select and bcd count in the bench itself and scores every result transfer
// depends on msc_pkg and the counter rtl
`timescale 1ns / 1ps

module testbench;
	import msc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX  = 10;

	// active-low segment bytes, digit 0 in the lowest byte
	localparam logic [9:0][7:0] SEG_CODES = {
		8'h88, 8'h80, 8'hF8, 8'h82, 8'h8A, 8'h99, 8'hA8, 8'hA4, 8'hF9, 8'hC0
	};

	typedef struct packed {
		logic [3:0]         digit_enable;
		logic [7:0]         segment_pattern;
		logic [MODE_W-1:0]  active_mode;
		logic [COUNT_W-1:0] count_value;
	} display_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	// switch levels waiting to be sent and display results still owed by the block
	logic [3:0] tick_queue [$];
	display_t   expected_display [$];
	int         mismatches = 0;
	int         cycles = 0;
	logic       no_idle = 1'b0;

	// predicted block state
	logic [MODE_W-1:0]  cur_mode = MODE_IDLE;
	logic [3:0][3:0]    digits = '0;
	int                 scan_pos = 0;
	logic [10:0]        frames = '0;
	dwell_t             dwell_cfg = {DWELL_FOUR_RST, DWELL_THREE_RST, DWELL_TWO_RST, DWELL_ONE_RST};

	multiplexed_seven_segment_counter i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one tick of the display: mode select at frame start, then the shown digit
	function automatic display_t display_tick(input logic [3:0] sw_n);
		display_t    r;
		logic        taken;
		logic        carry;
		int          pos;
		int          idx;
		logic [16:0] value;
		taken = 1'b0;
		if (scan_pos == 0) begin
			for (int s = 1; s <= MODE_COUNT; s++) begin
				if (!taken && s != int'(cur_mode) && !sw_n[s-1]) begin
					cur_mode = MODE_W'(s);
					digits = '0;
					frames = '0;
					taken = 1'b1;
				end
			end
		end
		if (cur_mode == MODE_IDLE) begin
			r.digit_enable = 4'b0000;
			r.segment_pattern = SEG_BLANK;
			r.active_mode = MODE_IDLE;
			r.count_value = '0;
			scan_pos = 0;
		end else begin
			pos = scan_pos;
			if (pos >= int'(cur_mode))
				pos = 0;
			idx = int'(cur_mode) - 1 - pos;
			r.digit_enable = 4'b0001 << (MODE_COUNT - int'(cur_mode) + pos);
			r.segment_pattern = SEG_CODES[digits[idx]];
			r.active_mode = cur_mode;
			value = '0;
			for (int i = int'(cur_mode) - 1; i >= 0; i--)
				value = value * 10 + digits[i];
			r.count_value = value[COUNT_W-1:0];
			if (pos + 1 >= int'(cur_mode)) begin
				scan_pos = 0;
				frames = frames + 1;
				// a dwell of zero steps every frame, same as one
				if (frames >= {1'b0, dwell_cfg[cur_mode-1]}) begin
					frames = '0;
					carry = 1'b1;
					for (int i = 0; i < int'(cur_mode); i++) begin
						if (carry) begin
							if (digits[i] >= 4'd9) begin
								digits[i] = 4'd0;
							end else begin
								digits[i] = digits[i] + 4'd1;
								carry = 1'b0;
							end
						end
					end
				end
			end else begin
				scan_pos = pos + 1;
			end
		end
		return r;
	endfunction

	// driver: predict on each accepted tick, then load the next one or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_display.push_back(display_tick(s_tdata[3:0]));
			if (!s_tvalid || s_tready) begin
				if (tick_queue.size() != 0 && (no_idle || $urandom_range(99) >= 33)) begin
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0000, tick_queue.pop_front()};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure and scoring of each result transfer
	always @(posedge clk) begin : monitor
		display_t want;
		display_t got;
		if (arst_n) begin
			m_tready <= no_idle || ($urandom_range(99) >= 33);
			if (m_tvalid && m_tready) begin
				got.digit_enable = m_tdata[3:0];
				got.segment_pattern = m_tdata[11:4];
				got.active_mode = m_tdata[14:12];
				got.count_value = m_tdata[28:15];
				if (expected_display.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("result with nothing expected: %h", m_tdata);
					mismatches++;
				end else begin
					want = expected_display.pop_front();
					if (got.digit_enable !== want.digit_enable
							|| got.segment_pattern !== want.segment_pattern
							|| got.active_mode !== want.active_mode
							|| got.count_value !== want.count_value) begin
						if (mismatches < REPORT_MAX)
							$display("result mismatch: enable %b/%b seg %h/%h mode %0d/%0d count %0d/%0d (exp/got)",
								want.digit_enable, got.digit_enable,
								want.segment_pattern, got.segment_pattern,
								want.active_mode, got.active_mode,
								want.count_value, got.count_value);
						mismatches++;
					end
				end
			end
		end
	end

	task automatic dwell_write(input logic [REG_IDX_W-1:0] idx, input logic [DWELL_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {22'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		dwell_cfg[idx] = val;
	endtask

	task automatic dwell_write_all(input logic [DWELL_W-1:0] one, input logic [DWELL_W-1:0] two,
			input logic [DWELL_W-1:0] three, input logic [DWELL_W-1:0] four);
		dwell_write(REG_DWELL_ONE, one);
		dwell_write(REG_DWELL_TWO, two);
		dwell_write(REG_DWELL_THREE, three);
		dwell_write(REG_DWELL_FOUR, four);
	endtask

	// hold off until every sent tick has come back as a result
	// checked at the falling edge, once driver and monitor have settled
	task automatic wait_drained();
		do
			@(negedge clk);
		while (tick_queue.size() != 0 || s_tvalid || expected_display.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	// runs of held switch levels: mostly released, some single presses, some chords
	task automatic queue_switch_runs(input int unsigned count);
		logic [3:0]  pattern;
		int unsigned pick;
		int unsigned run;
		int unsigned sent;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 70)
				pattern = 4'hF;
			else if (pick < 88)
				pattern = ~(4'b0001 << $urandom_range(3));
			else
				pattern = 4'($urandom_range(15));
			run = $urandom_range(8, 1);
			repeat (run) tick_queue.push_back(pattern);
			sent += run;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: idle, first press, chord, own switch held, mid-frame press, downshifts
		tick_queue = {4'hF, 4'hF, 4'hE, 4'hF, 4'hF,
			4'h0, 4'hF, 4'hD, 4'hD, 4'hD, 4'hF,
			4'hF, 4'hB, 4'hB, 4'hF, 4'hF,
			4'h7, 4'hF, 4'hF, 4'hF,
			4'h3, 4'hF, 4'hF, 4'h8};
		wait_drained();

		// fastest stepping; two-digit mode left running long enough to wrap past 99
		dwell_write_all(10'd1, 10'd1, 10'd1, 10'd1);
		repeat (4) tick_queue.push_back(4'hD);
		wait_drained();
		no_idle <= 1'b1;
		repeat (230) tick_queue.push_back(4'hF);
		wait_drained();
		no_idle <= 1'b0;
		queue_switch_runs(250);
		wait_drained();

		// zero dwell, mixed and the top value
		dwell_write_all(10'd0, 10'd2, 10'd3, 10'd1023);
		queue_switch_runs(300);
		wait_drained();

		dwell_write_all(10'd1023, 10'd1023, 10'd1023, 10'd1023);
		queue_switch_runs(150);
		wait_drained();

		repeat (3) begin
			dwell_write_all(DWELL_W'($urandom_range(5, 1)), DWELL_W'($urandom_range(5, 1)),
				DWELL_W'($urandom_range(5, 1)), DWELL_W'($urandom_range(1023, 1)));
			queue_switch_runs(150);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_display.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
